@@ rtl/core/tank_fill_vent_sequencer_unit_assert.svh @@
// Assertion macros for the tank fill and vent sequencer
`ifndef TANK_FILL_VENT_SEQUENCER_UNIT_ASSERT_SVH
`define TANK_FILL_VENT_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define TFVS_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("tfvs: same-cycle check failed");

// next-cycle implication
`define TFVS_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("tfvs: next-cycle check failed");

`endif

@@ rtl/core/tfvs_pkg.sv @@
package tfvs_pkg;

	localparam int P_W       = 19;
	localparam int M_W       = 18;
	localparam int T_W       = 16;
	localparam int OP_W      = 3;
	localparam int ACT_W     = 3;
	localparam int MODE_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 19;

	typedef logic [OP_W-1:0] op_t;
	localparam op_t OP_SAMPLE      = 3'd0;
	localparam op_t OP_TICK        = 3'd1;
	localparam op_t OP_START       = 3'd2;
	localparam op_t OP_STOP        = 3'd3;
	localparam op_t OP_MANUAL      = 3'd4;
	localparam op_t OP_FILL_CLOSED = 3'd5;
	localparam op_t OP_VENT_CLOSED = 3'd6;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_PRESSURE_TARGET = 3'd0;
	localparam cfg_idx_t CFG_MASS_TARGET     = 3'd1;
	localparam cfg_idx_t CFG_FILL_OPEN_MS    = 3'd2;
	localparam cfg_idx_t CFG_VENT_OPEN_MS    = 3'd3;
	localparam cfg_idx_t CFG_WAIT_TICKS      = 3'd4;

	localparam logic [T_W-1:0] WAIT_TICKS_RST = 16'd1000;

	typedef enum logic [ACT_W-1:0] {
		ACT_NONE,
		ACT_READY,
		ACT_START,
		ACT_WAITING,
		ACT_FILLING,
		ACT_VENTING,
		ACT_MANUAL_STOP,
		ACT_STOP
	} act_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_READY,
		MODE_WAIT,
		MODE_FILL,
		MODE_VENT
	} mode_t;

	typedef enum logic [1:0] {
		TSEL_NONE,
		TSEL_FILL,
		TSEL_VENT
	} tsel_t;

	typedef struct packed {
		logic  win_wr;
		logic  med_start;
		logic  wait_load;
		logic  wait_dec;
		logic  held_clear;
		logic  out_load;
		logic  out_last;
		act_t  out_action;
		logic  out_cf;
		logic  out_cv;
		logic  out_of;
		logic  out_ov;
		tsel_t out_tsel;
		logic  out_med;
		mode_t out_mode;
	} cmd_t;

	typedef struct packed {
		logic batch_last;
		logic wait_more;
		logic cold;
		logic full;
		logic med_done;
	} stat_t;

endpackage

@@ rtl/core/tfvs_median.sv @@
module tfvs_median #(
	parameter int W = 19,
	parameter int N = 5,
	localparam int IDX_W = (N > 1) ? $clog2(N) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IDX_W-1:0]    wr_idx,
	input  logic signed [W-1:0] wr_data,
	input  logic                start,
	output logic                done,
	output logic signed [W-1:0] median
);

	localparam int CNT_W = $clog2(N + 1);
	localparam logic [CNT_W-1:0] MID = CNT_W'(N / 2);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(N - 1);

	logic signed [W-1:0] win_q [N];
	logic                busy_q;
	logic                done_q;
	logic [IDX_W-1:0]    idx_q;
	logic signed [W-1:0] med_q;
	logic signed [W-1:0] cand;
	logic [CNT_W-1:0]    lt_cnt;
	logic [CNT_W-1:0]    le_cnt;
	logic                hit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q[wr_idx] <= wr_data;
		end
	end

	// candidate is the median when fewer than MID+1 entries are below it
	// and more than MID entries are at or below it
	always_comb begin
		cand   = win_q[idx_q];
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < N; j++) begin
			lt_cnt = lt_cnt + CNT_W'(win_q[j] < cand);
			le_cnt = le_cnt + CNT_W'(win_q[j] <= cand);
		end
		hit = (lt_cnt <= MID) && (le_cnt > MID);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				if (idx_q == IDX_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q && hit) begin
			med_q <= cand;
		end
	end

	assign done   = done_q;
	assign median = med_q;

endmodule

@@ rtl/core/tfvs_datapath.sv @@
module tfvs_datapath #(
	parameter int MEDIAN_COUNT = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tfvs_pkg::cmd_t                     cmd,
	output tfvs_pkg::stat_t                    stat,
	input  logic                               cfg_we,
	input  tfvs_pkg::cfg_idx_t                 cfg_index,
	input  logic [tfvs_pkg::CFG_W-1:0]         cfg_data,
	input  logic signed [tfvs_pkg::P_W-1:0]    pressure_sample,
	input  logic signed [tfvs_pkg::M_W-1:0]    mass_sample,
	output logic                               last,
	output logic [tfvs_pkg::ACT_W-1:0]         action,
	output logic                               close_fill,
	output logic                               close_vent,
	output logic                               open_fill,
	output logic                               open_vent,
	output logic [tfvs_pkg::T_W-1:0]           open_time_ms,
	output logic                               median_valid,
	output logic signed [tfvs_pkg::P_W-1:0]    median_pressure,
	output logic signed [tfvs_pkg::M_W-1:0]    median_mass,
	output logic [tfvs_pkg::MODE_W-1:0]        mode
);
	import tfvs_pkg::*;

	localparam int IDX_W = (MEDIAN_COUNT > 1) ? $clog2(MEDIAN_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MEDIAN_COUNT - 1);

	logic signed [P_W-1:0] p_target_q;
	logic signed [M_W-1:0] m_target_q;
	logic [T_W-1:0]        fill_ms_q;
	logic [T_W-1:0]        vent_ms_q;
	logic [T_W-1:0]        wait_ticks_q;
	logic [T_W-1:0]        wait_cnt_q;
	logic [IDX_W-1:0]      bc_q;
	logic signed [P_W-1:0] held_p_q;
	logic signed [M_W-1:0] held_m_q;
	logic signed [P_W-1:0] p_med;
	logic signed [M_W-1:0] m_med;
	logic                  p_done;
	logic                  m_done;

	logic                  last_q;
	act_t                  action_q;
	logic                  cf_q;
	logic                  cv_q;
	logic                  of_q;
	logic                  ov_q;
	logic [T_W-1:0]        time_q;
	logic                  mv_q;
	logic signed [P_W-1:0] mp_q;
	logic signed [M_W-1:0] mm_q;
	mode_t                 mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_target_q   <= '0;
			m_target_q   <= '0;
			fill_ms_q    <= '0;
			vent_ms_q    <= '0;
			wait_ticks_q <= WAIT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESSURE_TARGET: p_target_q <= cfg_data[P_W-1:0];
				CFG_MASS_TARGET: m_target_q <= cfg_data[M_W-1:0];
				CFG_FILL_OPEN_MS: fill_ms_q <= cfg_data[T_W-1:0];
				CFG_VENT_OPEN_MS: vent_ms_q <= cfg_data[T_W-1:0];
				CFG_WAIT_TICKS: wait_ticks_q <= cfg_data[T_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wait_cnt_q <= '0;
			bc_q       <= '0;
			held_p_q   <= '0;
			held_m_q   <= '0;
		end else begin
			if (cmd.wait_load) begin
				wait_cnt_q <= wait_ticks_q;
			end else if (cmd.wait_dec) begin
				wait_cnt_q <= wait_cnt_q - 1'b1;
			end
			if (cmd.win_wr) begin
				bc_q <= (bc_q == IDX_LAST) ? '0 : bc_q + 1'b1;
			end
			if (cmd.held_clear) begin
				held_p_q <= '0;
				held_m_q <= '0;
			end else if (stat.med_done) begin
				held_p_q <= p_med;
				held_m_q <= m_med;
			end
		end
	end

	tfvs_median #(.W(P_W), .N(MEDIAN_COUNT)) u_med_p (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd.win_wr),
		.wr_idx  (bc_q),
		.wr_data (pressure_sample),
		.start   (cmd.med_start),
		.done    (p_done),
		.median  (p_med)
	);

	tfvs_median #(.W(M_W), .N(MEDIAN_COUNT)) u_med_m (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd.win_wr),
		.wr_idx  (bc_q),
		.wr_data (mass_sample),
		.start   (cmd.med_start),
		.done    (m_done),
		.median  (m_med)
	);

	always_comb begin
		stat.batch_last = (bc_q == IDX_LAST);
		stat.wait_more  = (wait_cnt_q > T_W'(1));
		stat.cold       = (held_p_q <= p_target_q);
		stat.full       = (held_m_q >= m_target_q);
		stat.med_done   = p_done & m_done;
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last_q   <= cmd.out_last;
			action_q <= cmd.out_action;
			cf_q     <= cmd.out_cf;
			cv_q     <= cmd.out_cv;
			of_q     <= cmd.out_of;
			ov_q     <= cmd.out_ov;
			case (cmd.out_tsel)
				TSEL_FILL: time_q <= fill_ms_q;
				TSEL_VENT: time_q <= vent_ms_q;
				default: time_q <= '0;
			endcase
			mv_q     <= cmd.out_med;
			mp_q     <= cmd.out_med ? p_med : '0;
			mm_q     <= cmd.out_med ? m_med : '0;
			mode_q   <= cmd.out_mode;
		end
	end

	assign last            = last_q;
	assign action          = action_q;
	assign close_fill      = cf_q;
	assign close_vent      = cv_q;
	assign open_fill       = of_q;
	assign open_vent       = ov_q;
	assign open_time_ms    = time_q;
	assign median_valid    = mv_q;
	assign median_pressure = mp_q;
	assign median_mass     = mm_q;
	assign mode            = mode_q;

endmodule

@@ rtl/core/tfvs_ctrl.sv @@
`include "tank_fill_vent_sequencer_unit_assert.svh"

module tfvs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  tfvs_pkg::op_t   operation,
	output logic            result_valid,
	input  logic            result_stall,
	input  tfvs_pkg::stat_t stat,
	output tfvs_pkg::cmd_t  cmd
);
	import tfvs_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MED,
		S_HEAD,
		S_TAIL
	} state_t;

	state_t state_q;
	state_t state_d;
	mode_t  mode_q;
	mode_t  mode_d;
	act_t   second_q;
	act_t   second_d;
	logic   result_valid_q;
	logic   acc;

	assign item_stall   = (state_q != S_IDLE);
	assign acc          = item_valid && !item_stall;
	assign result_valid = result_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		mode_d   = mode_q;
		second_d = second_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (operation)
						OP_SAMPLE: begin
							cmd.win_wr = 1'b1;
							if (stat.batch_last) begin
								cmd.med_start = 1'b1;
								state_d       = S_MED;
							end
						end
						OP_TICK: begin
							if (mode_q == MODE_WAIT) begin
								if (stat.wait_more) begin
									cmd.wait_dec = 1'b1;
								end else if (stat.cold && !stat.full) begin
									mode_d         = MODE_FILL;
									cmd.out_load   = 1'b1;
									cmd.out_last   = 1'b1;
									cmd.out_action = ACT_FILLING;
									cmd.out_of     = 1'b1;
									cmd.out_tsel   = TSEL_FILL;
									state_d        = S_TAIL;
								end else if (!stat.cold) begin
									mode_d         = MODE_VENT;
									cmd.out_load   = 1'b1;
									cmd.out_last   = 1'b1;
									cmd.out_action = ACT_VENTING;
									cmd.out_ov     = 1'b1;
									cmd.out_tsel   = TSEL_VENT;
									state_d        = S_TAIL;
								end else begin
									cmd.wait_load = 1'b1;
								end
							end
						end
						OP_START: begin
							if (mode_q == MODE_READY) begin
								mode_d         = MODE_WAIT;
								cmd.held_clear = 1'b1;
								cmd.wait_load  = 1'b1;
								cmd.out_load   = 1'b1;
								cmd.out_action = ACT_START;
								cmd.out_cf     = 1'b1;
								cmd.out_cv     = 1'b1;
								second_d       = ACT_WAITING;
								state_d        = S_HEAD;
							end
						end
						OP_STOP, OP_MANUAL: begin
							if (mode_q != MODE_READY) begin
								mode_d         = MODE_READY;
								cmd.out_load   = 1'b1;
								cmd.out_cf     = 1'b1;
								cmd.out_cv     = (operation == OP_STOP);
								cmd.out_action = (operation == OP_STOP) ? ACT_STOP
									: ACT_MANUAL_STOP;
								second_d       = ACT_READY;
								state_d        = S_HEAD;
							end
						end
						OP_FILL_CLOSED, OP_VENT_CLOSED: begin
							if ((operation == OP_FILL_CLOSED && mode_q == MODE_FILL) ||
								(operation == OP_VENT_CLOSED && mode_q == MODE_VENT)) begin
								mode_d         = MODE_WAIT;
								cmd.wait_load  = 1'b1;
								cmd.out_load   = 1'b1;
								cmd.out_last   = 1'b1;
								cmd.out_action = ACT_WAITING;
								state_d        = S_TAIL;
							end
						end
						default: ;
					endcase
				end
			end
			S_MED: begin
				if (stat.med_done) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_med    = 1'b1;
					cmd.out_action = ACT_NONE;
					state_d        = S_TAIL;
				end
			end
			S_HEAD: begin
				if (!result_stall) begin
					cmd.out_load   = 1'b1;
					cmd.out_last   = 1'b1;
					cmd.out_action = second_q;
					state_d        = S_TAIL;
				end
			end
			S_TAIL: begin
				if (!result_stall) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.out_mode = mode_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			mode_q         <= MODE_READY;
			second_q       <= ACT_NONE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			mode_q         <= mode_d;
			second_q       <= second_d;
			result_valid_q <= (state_d == S_HEAD) || (state_d == S_TAIL);
		end
	end

	`TFVS_ASSERT_IMP(a_stall_while_result, clk, arst_n, result_valid, item_stall)
	`TFVS_ASSERT_NXT(a_head_to_tail, clk, arst_n, (state_q == S_HEAD) && !result_stall, (state_q == S_TAIL) && result_valid)
	`TFVS_ASSERT_NXT(a_start_enters_wait, clk, arst_n, acc && (operation == OP_START) && (mode_q == MODE_READY), (mode_q == MODE_WAIT) && result_valid)
	`TFVS_ASSERT_NXT(a_median_result, clk, arst_n, (state_q == S_MED) && stat.med_done, (state_q == S_TAIL) && result_valid)
	`TFVS_ASSERT_IMP(a_start_with_write, clk, arst_n, cmd.med_start, cmd.win_wr && acc)

endmodule

@@ rtl/core/tank_fill_vent_sequencer_unit.sv @@
// Fill and vent sequencer for a cold tank.
// Input channel (item_valid / item_stall) takes one word per operation:
// sample, tick, start, stop, manual action, fill or vent valve closed.
// Result channel (result_valid / result_stall) returns zero, one or two
// words per input; last marks the final word of an input.
// Config channel (cfg_valid / cfg_ready, always ready) writes the targets,
// valve open times and the wait length; write only while the block is idle.
// A result word is registered and shows in the cycle after its input is taken.
// A sample that closes a batch runs a median scan, one candidate per cycle over
// the MEDIAN_COUNT stored entries; its word is loaded once both scans are done.
// Throughput: inputs with no result can be taken every cycle; an input with
// result words holds off the next input until its last word is taken, and
// longer while the receiver stalls.
// A stalled result word holds and item_stall stays high until the last
// word of the input is taken; one input is in flight at a time.
// Reset: mode ready, wait count, batch count and held medians cleared,
// config to its defaults (wait_ticks 1000, the rest 0).
module tank_fill_vent_sequencer_unit #(
	parameter int MEDIAN_COUNT = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  logic [tfvs_pkg::OP_W-1:0]          operation,
	input  logic signed [tfvs_pkg::P_W-1:0]    pressure_sample,
	input  logic signed [tfvs_pkg::M_W-1:0]    mass_sample,
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               last,
	output logic [tfvs_pkg::ACT_W-1:0]         action,
	output logic                               close_fill,
	output logic                               close_vent,
	output logic                               open_fill,
	output logic                               open_vent,
	output logic [tfvs_pkg::T_W-1:0]           open_time_ms,
	output logic                               median_valid,
	output logic signed [tfvs_pkg::P_W-1:0]    median_pressure,
	output logic signed [tfvs_pkg::M_W-1:0]    median_mass,
	output logic [tfvs_pkg::MODE_W-1:0]        mode,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tfvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfvs_pkg::CFG_W-1:0]         cfg_data
);
	import tfvs_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	tfvs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	tfvs_datapath #(.MEDIAN_COUNT(MEDIAN_COUNT)) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pressure_sample (pressure_sample),
		.mass_sample     (mass_sample),
		.last            (last),
		.action          (action),
		.close_fill      (close_fill),
		.close_vent      (close_vent),
		.open_fill       (open_fill),
		.open_vent       (open_vent),
		.open_time_ms    (open_time_ms),
		.median_valid    (median_valid),
		.median_pressure (median_pressure),
		.median_mass     (median_mass),
		.mode            (mode)
	);

endmodule
